/* design/dbw_pkg.sv */
`default_nettype none

package dbw_pkg;

  // Field widths
  localparam int TICK_W     = 64;
  localparam int BUSY_W     = 15;
  localparam int SUM_OUT_W  = 21;
  localparam int WLEN_W     = 7;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;

  // Busy level of a fully busy interval, in 1/256 percent
  localparam logic [BUSY_W-1:0] BUSY_FULL = 15'd25600;

  // Product delta * 25600 needs 64 + 15 bits; the quotient has 15 bits
  localparam int PROD_W    = TICK_W + BUSY_W;
  localparam int DIV_STEPS = BUSY_W;

  // Register reset values and default window depth
  localparam int                    MAX_WINDOW_DEF = 64;
  localparam logic [BUSY_W-1:0]     THRESH_RESET   = 15'd20480;
  localparam logic [WLEN_W-1:0]     WLEN_RESET     = 7'd10;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0]  REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_WINDOW_LEN = 2'd1;

endpackage

`default_nettype wire

/* design/dbw_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in BUSY_W bits, so the upper numerator bits are already
// below the divisor and seed the remainder directly.
module dbw_div
  import dbw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] numerator,
  input  wire logic [TICK_W-1:0] divisor,
  output logic                   done,
  output logic [BUSY_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [TICK_W-1:0] rem;
  logic [BUSY_W-1:0] low_bits;
  logic [TICK_W:0]   trial;
  logic              ge;

  // Shift the next numerator bit in and try the subtraction
  assign trial = {rem, low_bits[BUSY_W-1]};
  assign ge    = (trial >= {1'b0, divisor});

  // Control: step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DIV_STEPS);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, remaining numerator bits, quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= numerator[PROD_W-1:BUSY_W];
      low_bits <= numerator[BUSY_W-1:0];
      quotient <= '0;
    end else if (run) begin
      low_bits <= {low_bits[BUSY_W-2:0], 1'b0};
      quotient <= {quotient[BUSY_W-2:0], ge};
      if (ge) begin
        rem <= TICK_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[TICK_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* design/dbw_hist.sv */
`default_nettype none

// Sample history: one write port, one registered read port
module dbw_hist
  import dbw_pkg::*;
#(
  parameter int DEPTH = MAX_WINDOW_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [BUSY_W-1:0] wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic [BUSY_W-1:0]      rd_data
);

  logic [BUSY_W-1:0] mem [DEPTH];

  // Write when enabled, read every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* design/disk_busy_window_detector.sv */
`default_nettype none

// Disk busy window detector.
// Input stream: one transaction per sample; s_axis_tuser is the sample-valid
// flag, s_axis_tdata carries the busy counter and the timestamp (both ms).
// Output stream: one transaction per input transaction, with the busy level
// of the sample (1/256 percent), the window sum, window-full, over-threshold
// and, in m_axis_tuser, the read-error flag for an invalid sample.
// Configuration channel: index 0 sets the busy threshold, index 1 sets the
// window length and clears the window; writes are taken while idle.
// Sequence: an invalid sample goes from acceptance straight to the result
// state; a valid one passes the delta, prep, divide (only when needed) and
// update states first, the divide running the 15-step restoring divider.
// One sample is in work at a time: no new one is taken before it is done.
// A finished result waits in the output register, so the next sample is
// accepted while the receiver stalls; a second result then waits inside.
// Reset restores the register defaults and empties the window and the
// previous-sample state; the history needs no clearing.
module disk_busy_window_detector
  import dbw_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // fields from bit 0: busy_ticks[63:0], time_ms[127:64]
  input  wire logic [2*TICK_W-1:0]   s_axis_tdata,
  // fields from bit 0: sample_valid
  input  wire logic                  s_axis_tuser,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // fields from bit 0: over_threshold, window_full, busy_sample[16:2],
  // busy_sum[37:17], zero fill[39:38]
  output logic [39:0]                m_axis_tdata,
  // fields from bit 0: read_error
  output logic                       m_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int LCMP_W = (CW > WLEN_W) ? CW : WLEN_W;
  localparam int SUM_W = $clog2(25600 * MAX_WINDOW + 1);
  localparam int TH_W  = BUSY_W + CW;
  localparam int CMP_W = (SUM_W > TH_W) ? SUM_W : TH_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DELTA  = 6'b000010,
    S_PREP   = 6'b000100,
    S_DIV    = 6'b001000,
    S_UPDATE = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers
  logic [BUSY_W-1:0] busy_threshold;
  logic [WLEN_W-1:0] window_length;

  // Sample and window state
  logic [TICK_W-1:0] prev_ticks;
  logic [TICK_W-1:0] prev_time;
  logic              have_prev;
  logic [AW-1:0]     head;
  logic [CW-1:0]     fill;
  logic [SUM_W-1:0]  window_sum;

  // Per-item working registers
  logic [TICK_W-1:0] in_ticks;
  logic [TICK_W-1:0] in_time;
  logic [TICK_W-1:0] delta;
  logic [TICK_W-1:0] elapsed;
  logic              calc;
  logic              res_err;
  logic [BUSY_W-1:0] busy_val;

  // Output register
  logic              out_valid;
  logic              out_over;
  logic              out_full;
  logic              out_err;
  logic [BUSY_W-1:0] out_busy;
  logic [SUM_OUT_W-1:0] out_sum;

  logic              in_acc;
  logic              cfg_acc;
  logic              load_out;
  logic [CW-1:0]     len;
  logic [LCMP_W-1:0] wl_ext;
  logic [CW-1:0]     head_ext;
  logic [CW-1:0]     head_inc;
  logic [PROD_W-1:0] delta_ext;
  logic [PROD_W-1:0] product;
  logic              div_start;
  logic              div_done;
  logic [BUSY_W-1:0] div_quo;
  logic [BUSY_W-1:0] old_busy;
  logic              hist_we;
  logic [TH_W-1:0]   th_len;
  logic              res_full;
  logic              res_over;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid && cfg_ready;

  // Effective window length: zero counts as one, saturate at the depth
  assign wl_ext = LCMP_W'(window_length);
  always_comb begin
    if (window_length == '0) begin
      len = CW'(1);
    end else if (wl_ext > LCMP_W'(MAX_WINDOW)) begin
      len = CW'(MAX_WINDOW);
    end else begin
      len = wl_ext[CW-1:0];
    end
  end

  assign head_ext = CW'(head);
  assign head_inc = head_ext + CW'(1);

  // delta * 25600 = delta * (2^14 + 2^13 + 2^10)
  assign delta_ext = PROD_W'(delta);
  assign product   = (delta_ext << 14) + (delta_ext << 13) + (delta_ext << 10);

  assign div_start = (state == S_PREP) && calc && (elapsed != '0) && (delta < elapsed);
  assign hist_we   = (state == S_UPDATE);

  // Result flags from the settled window
  assign th_len   = TH_W'(busy_threshold) * TH_W'(len);
  assign res_full = (fill == len);
  assign res_over = !res_err && res_full && (CMP_W'(window_sum) > CMP_W'(th_len));
  assign load_out = (state == S_RESULT) && (!out_valid || m_axis_tready);

  dbw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numerator (product),
    .divisor   (elapsed),
    .done      (div_done),
    .quotient  (div_quo)
  );

  dbw_hist #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (head),
    .wr_data (busy_val),
    .rd_addr (head),
    .rd_data (old_busy)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      busy_threshold <= THRESH_RESET;
      window_length  <= WLEN_RESET;
      prev_ticks     <= '0;
      prev_time      <= '0;
      have_prev      <= 1'b0;
      head           <= '0;
      fill           <= '0;
      window_sum     <= '0;
      out_valid      <= 1'b0;
    end else begin
      // Load a new result, or drop the output once taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_THRESHOLD: busy_threshold <= cfg_data[BUSY_W-1:0];
          REG_WINDOW_LEN: begin
            window_length <= cfg_data[WLEN_W-1:0];
            head          <= '0;
            fill          <= '0;
            window_sum    <= '0;
          end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= s_axis_tuser ? S_DELTA : S_RESULT;
          end
        end
        S_DELTA: begin
          prev_ticks <= in_ticks;
          prev_time  <= in_time;
          have_prev  <= 1'b1;
          if (head_ext >= len) begin
            head <= '0;
          end
          state <= S_PREP;
        end
        S_PREP: begin
          state <= div_start ? S_DIV : S_UPDATE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // Retire the oldest sample once the window is full
          if (fill >= len) begin
            window_sum <= window_sum - SUM_W'(old_busy) + SUM_W'(busy_val);
            fill       <= len;
          end else begin
            window_sum <= window_sum + SUM_W'(busy_val);
            fill       <= fill + CW'(1);
          end
          head  <= (head_inc >= len) ? '0 : head_inc[AW-1:0];
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Per-item datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_ticks <= s_axis_tdata[TICK_W-1:0];
      in_time  <= s_axis_tdata[2*TICK_W-1:TICK_W];
      res_err  <= !s_axis_tuser;
    end
    if (state == S_DELTA) begin
      delta   <= in_ticks - prev_ticks;
      elapsed <= in_time - prev_time;
      calc    <= have_prev;
    end
    if (state == S_PREP) begin
      if (!calc || (elapsed == '0)) begin
        busy_val <= '0;
      end else if (delta >= elapsed) begin
        busy_val <= BUSY_FULL;
      end
    end
    if ((state == S_DIV) && div_done) begin
      busy_val <= div_quo;
    end
    // Hold the result fields until the receiver takes them
    if (load_out) begin
      out_over <= res_over;
      out_full <= res_full;
      out_err  <= res_err;
      out_busy <= res_err ? '0 : busy_val;
      out_sum  <= SUM_OUT_W'(window_sum);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_err;
  assign m_axis_tdata  = {2'b00, out_sum, out_busy, out_full, out_over};

endmodule

`default_nettype wire
